### rtl/core/gmspc_pkg.sv
// Shared types, constants and a helper function of the grid max-score path counter.
package gmspc_pkg;

    localparam int CFG_W        = 8;
    localparam int KIND_W       = 2;
    localparam int DIGIT_W      = 4;
    localparam int SCORE_W      = 12;
    localparam int COUNT_W      = 30;
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 48;
    localparam int SUM_W        = 32;

    localparam int DEF_MAX_GRID = 128;

    localparam logic [CFG_W-1:0]   GRID_RESET = 8'd128;
    localparam logic [COUNT_W-1:0] PATH_MOD   = 30'd1000000007;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 12'd4095;

    localparam logic [KIND_W-1:0] KIND_DIGIT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARKER   = 2'd2;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
        logic               reach;
    } t_cell;

    typedef struct packed {
        logic is_start;
        logic has_below;
        logic has_right;
        logic is_final;
    } t_pos_flags;

    // Last row/column index for a programmed size, clamped to 1..max_grid.
    function automatic int grid_last(input logic [CFG_W-1:0] size, input int max_grid);
        int s;
        s = int'(size);
        if (s == 0) begin
            return 0;
        end
        if (s > max_grid) begin
            return max_grid - 1;
        end
        return s - 1;
    endfunction

endpackage

### rtl/core/gmspc_ctrl.sv
// Grid size register and reverse raster position counters.
module gmspc_ctrl #(
    parameter int MAX_GRID = gmspc_pkg::DEF_MAX_GRID,
    parameter int POS_W    = $clog2(MAX_GRID)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gmspc_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_advance,
    output logic [POS_W-1:0]           o_col,
    output gmspc_pkg::t_pos_flags      o_flags
);

    logic [gmspc_pkg::CFG_W-1:0] r_grid_size;
    logic [POS_W-1:0]            r_row;
    logic [POS_W-1:0]            r_col;
    logic [POS_W-1:0]            w_last;
    logic [POS_W-1:0]            w_cfg_last;

    assign w_last     = POS_W'(gmspc_pkg::grid_last(r_grid_size, MAX_GRID));
    assign w_cfg_last = POS_W'(gmspc_pkg::grid_last(i_cfg_wdata, MAX_GRID));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= gmspc_pkg::GRID_RESET;
            r_row       <= POS_W'(gmspc_pkg::grid_last(gmspc_pkg::GRID_RESET, MAX_GRID));
            r_col       <= POS_W'(gmspc_pkg::grid_last(gmspc_pkg::GRID_RESET, MAX_GRID));
        end else if (i_cfg_we) begin
            r_grid_size <= i_cfg_wdata;
            r_row       <= w_cfg_last;
            r_col       <= w_cfg_last;
        end else if (i_advance) begin
            if (r_col == '0) begin
                r_col <= w_last;
                r_row <= (r_row == '0) ? w_last : r_row - POS_W'(1);
            end else begin
                r_col <= r_col - POS_W'(1);
            end
        end
    end

    assign o_col             = r_col;
    assign o_flags.is_start  = (r_row == w_last) && (r_col == w_last);
    assign o_flags.has_below = (r_row != w_last);
    assign o_flags.has_right = (r_col != w_last);
    assign o_flags.is_final  = (r_row == '0) && (r_col == '0);

endmodule

### rtl/core/gmspc_row_mem.sv
// Row store: one entry per column holding the row below, registered read.
module gmspc_row_mem #(
    parameter int DEPTH  = gmspc_pkg::DEF_MAX_GRID,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  gmspc_pkg::t_cell  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output gmspc_pkg::t_cell  o_rdata
);

    gmspc_pkg::t_cell r_mem [DEPTH];
    gmspc_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/gmspc_cell.sv
// Cell update: best neighbour score, tie count sum modulo the path modulus.
module gmspc_cell (
    input  logic [gmspc_pkg::KIND_W-1:0]  i_kind,
    input  logic [gmspc_pkg::DIGIT_W-1:0] i_digit,
    input  gmspc_pkg::t_pos_flags         i_flags,
    input  gmspc_pkg::t_cell              i_below,
    input  gmspc_pkg::t_cell              i_right,
    input  gmspc_pkg::t_cell              i_diag,
    output gmspc_pkg::t_cell              o_cur
);

    localparam int SW = gmspc_pkg::SCORE_W;
    localparam int CW = gmspc_pkg::COUNT_W;
    localparam int UW = gmspc_pkg::SUM_W;

    logic          w_vb, w_vr, w_vd, w_any, w_open;
    logic [SW-1:0] w_sb, w_sr, w_sd, w_max_br, w_best;
    logic [UW-1:0] w_sum, w_mod1, w_mod2;
    logic [CW-1:0] w_count;
    logic [SW:0]   w_score_ext;
    logic [SW-1:0] w_add;

    always_comb begin
        w_vb = i_flags.has_below && i_below.reach;
        w_vr = i_flags.has_right && i_right.reach;
        w_vd = i_flags.has_below && i_flags.has_right && i_diag.reach;
        w_any = w_vb || w_vr || w_vd;
        // Kind three counts as an obstacle.
        w_open = (i_kind == gmspc_pkg::KIND_DIGIT) || (i_kind == gmspc_pkg::KIND_MARKER);

        // Masked scores of zero never exceed a real score, so a plain max works.
        w_sb = w_vb ? i_below.score : '0;
        w_sr = w_vr ? i_right.score : '0;
        w_sd = w_vd ? i_diag.score  : '0;
        w_max_br = (w_sb > w_sr) ? w_sb : w_sr;
        w_best   = (w_sd > w_max_br) ? w_sd : w_max_br;

        w_sum = ((w_vb && (w_sb == w_best)) ? UW'(i_below.count) : '0)
              + ((w_vr && (w_sr == w_best)) ? UW'(i_right.count) : '0)
              + ((w_vd && (w_sd == w_best)) ? UW'(i_diag.count)  : '0);
        w_mod1 = UW'(gmspc_pkg::PATH_MOD);
        w_mod2 = UW'(gmspc_pkg::PATH_MOD) << 1;
        if (w_sum >= w_mod2) begin
            w_count = CW'(w_sum - w_mod2);
        end else if (w_sum >= w_mod1) begin
            w_count = CW'(w_sum - w_mod1);
        end else begin
            w_count = CW'(w_sum);
        end

        w_add = (i_kind == gmspc_pkg::KIND_DIGIT) ? SW'(i_digit) : '0;
        w_score_ext = {1'b0, w_best} + {1'b0, w_add};

        if (i_flags.is_start) begin
            o_cur.reach = 1'b1;
            o_cur.score = '0;
            o_cur.count = CW'(1);
        end else if (w_open && w_any) begin
            o_cur.reach = 1'b1;
            o_cur.score = w_score_ext[SW] ? gmspc_pkg::SCORE_MAX : w_score_ext[SW-1:0];
            o_cur.count = w_count;
        end else begin
            o_cur.reach = 1'b0;
            o_cur.score = '0;
            o_cur.count = '0;
        end
    end

endmodule

### rtl/core/grid_max_score_path_count_core.sv
// Grid max-score path counter top level: handshakes, pipeline and result register.
//
// Cells stream in reverse raster order (bottom-right first, top-left last),
// one transaction per cycle sustained. The accepting edge captures a cell in the
// input register and reads its row-store entry (the cell below) at the same time.
// The cell update then runs from the input register, and the edge at which it
// fires writes the row store, the right and below-right neighbor registers and,
// for the top-left cell, the result register. One cell per cycle is possible
// because each update needs only the previous cell's result, and that result
// comes back through the right neighbor register. The output is a register, so
// the next grid can stream in while a result waits. Only the top-left cell of a
// following grid stalls while an untaken result is held.
// Writing grid_size restarts the grid at the bottom-right corner; write it only
// while the block is idle. Sizes of zero act as one, sizes above MAX_GRID as
// MAX_GRID. An unreachable top-left cell reports score 0 and count 0.
module grid_max_score_path_count_core #(
    parameter int MAX_GRID = gmspc_pkg::DEF_MAX_GRID
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gmspc_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gmspc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [3:0] cell_digit
    input  logic [gmspc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // [1:0] cell_kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gmspc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [11:0] max_score, [41:12] path_count
);

    localparam int POS_W = $clog2(MAX_GRID);
    localparam int SW    = gmspc_pkg::SCORE_W;
    localparam int CW    = gmspc_pkg::COUNT_W;

    logic                  w_accept;
    logic                  w_fire;
    logic [POS_W-1:0]      w_col;
    gmspc_pkg::t_pos_flags w_flags;
    gmspc_pkg::t_cell      w_below;
    gmspc_pkg::t_cell      n_cur;

    logic                            r_b_valid;
    logic [gmspc_pkg::KIND_W-1:0]    r_b_kind;
    logic [gmspc_pkg::DIGIT_W-1:0]   r_b_digit;
    logic [POS_W-1:0]                r_b_col;
    gmspc_pkg::t_pos_flags           r_b_flags;
    gmspc_pkg::t_cell                r_right;
    gmspc_pkg::t_cell                r_diag;
    logic                            r_out_valid;
    logic [SW-1:0]                   r_out_score;
    logic [CW-1:0]                   r_out_count;

    // Hold the final cell while an earlier result is still untaken.
    assign w_fire = r_b_valid && (!r_b_flags.is_final || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_b_valid || w_fire;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    gmspc_ctrl #(
        .MAX_GRID (MAX_GRID),
        .POS_W    (POS_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_accept),
        .o_col       (w_col),
        .o_flags     (w_flags)
    );

    gmspc_row_mem #(
        .DEPTH  (MAX_GRID),
        .ADDR_W (POS_W)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_b_col),
        .i_wdata (n_cur),
        .i_re    (w_accept),
        .i_raddr (w_col),
        .o_rdata (w_below)
    );

    gmspc_cell u_cell (
        .i_kind  (r_b_kind),
        .i_digit (r_b_digit),
        .i_flags (r_b_flags),
        .i_below (w_below),
        .i_right (r_right),
        .i_diag  (r_diag),
        .o_cur   (n_cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_accept) begin
            r_b_valid <= 1'b1;
        end else if (w_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_kind  <= s_axis_tuser[gmspc_pkg::KIND_W-1:0];
            r_b_digit <= s_axis_tdata[gmspc_pkg::DIGIT_W-1:0];
            r_b_col   <= w_col;
            r_b_flags <= w_flags;
        end
    end

    // Right neighbor and below-right neighbor; clear on reset and restart.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_right <= '0;
            r_diag  <= '0;
        end else if (w_fire) begin
            r_right <= n_cur;
            r_diag  <= w_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_b_flags.is_final) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_b_flags.is_final) begin
            r_out_score <= n_cur.reach ? n_cur.score : '0;
            r_out_count <= n_cur.reach ? n_cur.count : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(gmspc_pkg::OUT_TDATA_W - SW - CW)'(0), r_out_count, r_out_score};

endmodule
